// ===== src/scds_pkg.sv =====
// types, constants and codes of the serial clock divider search
package scds_pkg;

  localparam int unsigned HZ_W      = 27;
  localparam int unsigned PRE_W     = 9;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned LIM_W     = 25;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned PROD_W    = 16;
  localparam int unsigned RATE_P_W  = LIM_W + PROD_W;

  localparam logic [HZ_W-1:0]    INTERNAL_HZ       = HZ_W'(16000000);
  localparam logic [HZ_W-1:0]    SYSCLK_RESET_HZ   = HZ_W'(16000000);
  localparam logic [HZ_W-1:0]    MASTER_CAP_HZ     = HZ_W'(25000000);
  localparam logic [HZ_W-1:0]    SLAVE_CAP_HZ      = HZ_W'(6670000);
  localparam logic [MUL_B_W-1:0] RECIP3            = 32'hAAAAAAAB;
  localparam int unsigned        RECIP3_SHIFT      = 33;
  localparam logic [PRE_W-1:0]   PRE_IDX_NONE      = PRE_W'(254 / 2);
  localparam logic [PRE_W-1:0]   DIV_MAX           = PRE_W'(256);
  localparam logic [PRE_W-1:0]   FAIL_PRESCALER    = PRE_W'(256);

  localparam logic [1:0] REG_SOURCE_SELECT = 2'd0;
  localparam logic [1:0] REG_SYSTEM_CLOCK  = 2'd1;
  localparam logic [1:0] REG_MASTER_MODE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_CLAMP,
    ST_PROD,
    ST_SCALE,
    ST_TEST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            source_select;
    logic [HZ_W-1:0] system_clock_hz;
    logic            master_mode;
  } cfg_t;

  typedef struct packed {
    logic [PRE_W-1:0]  even_prescaler;
    logic [RATE_W-1:0] rate_field;
    logic              no_fit;
  } res_t;

endpackage

// ===== src/scds_in_if.sv =====
// request channel carrying the target bit rate
interface scds_in_if
  import scds_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [HZ_W-1:0] target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink (input valid, input target_hz, output ready);
endinterface

// ===== src/scds_out_if.sv =====
// result channel carrying prescaler, rate field and no-fit flag
interface scds_out_if
  import scds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PRE_W-1:0]  even_prescaler;
  logic [RATE_W-1:0] rate_field;
  logic              no_fit;

  modport source (output valid, output even_prescaler, output rate_field, output no_fit,
                  input ready);
  modport sink (input valid, input even_prescaler, input rate_field, input no_fit,
                output ready);
endinterface

// ===== src/serial_clock_divider_search.sv =====
// top level of the serial clock divider search
//
// req_i carries one word, the requested bit rate target_hz; rsp_o returns one
// word per request: even_prescaler, rate_field (divisor minus one) and no_fit.
// both channels move a word at a clock edge where valid and ready are high.
// source select, system clock and master mode are written over the apb port;
// the user is to write them while no request is in flight, which the block
// itself does not enforce; pready is always high and reads return the register value.
// a request runs from acceptance until its result sits in the output
// register through the setup states RECIP and CLAMP, seven probes over the
// prescaler and eight over the divisor (only the prescaler probes when no
// prescaler fits), each probe stepping through PROD, SCALE and TEST on the
// one shared multiplier. one request is worked on at a time; req_i.ready is
// high only while the sequencer is idle, once its last result has been taken.
// the output register holds a finished word while rsp_o.ready is low, and a
// new request may be accepted meanwhile; its result waits in the sequencer
// until the register frees up.
// reset clears the registers to source internal 16 MHz, system clock
// 16 MHz, master mode, and leaves the block idle with no result pending.
module serial_clock_divider_search
  import scds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  scds_in_if.sink           req_i,
  scds_out_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  res_t               res;
  res_t               out_q;
  logic               out_valid_q;
  logic               res_valid;
  logic               res_take;
  logic               seq_ready;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  scds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scds_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  scds_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (req_i.valid),
    .in_target_hz_i (req_i.target_hz),
    .in_ready_o     (seq_ready),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take),
    .mul_a_o        (mul_a),
    .mul_b_o        (mul_b),
    .mul_p_i        (mul_p)
  );

  assign req_i.ready = seq_ready;
  assign res_take    = res_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.even_prescaler = out_q.even_prescaler;
  assign rsp_o.rate_field     = out_q.rate_field;
  assign rsp_o.no_fit         = out_q.no_fit;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a search is running");

  a_no_fit_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.no_fit |->
      (rsp_o.even_prescaler == FAIL_PRESCALER) && (rsp_o.rate_field == '0))
    else $error("no-fit word with prescaler or rate field set");

  a_fit_prescaler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.no_fit |->
      !rsp_o.even_prescaler[0] && (rsp_o.even_prescaler != '0) &&
      (rsp_o.even_prescaler != FAIL_PRESCALER))
    else $error("fitting word with a prescaler out of range");

  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> res_valid && (!out_valid_q || rsp_o.ready))
    else $error("result loaded over a word still pending");

endmodule

// ===== src/scds_cfg.sv =====
// apb register file for source select, system clock and mode
module scds_cfg
  import scds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_select   <= 1'b0;
      cfg_q.system_clock_hz <= SYSCLK_RESET_HZ;
      cfg_q.master_mode     <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SOURCE_SELECT: cfg_q.source_select   <= pwdata[0];
        REG_SYSTEM_CLOCK:  cfg_q.system_clock_hz <= pwdata[HZ_W-1:0];
        REG_MASTER_MODE:   cfg_q.master_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SOURCE_SELECT: prdata = {{(DATA_W-1){1'b0}}, cfg_q.source_select};
      REG_SYSTEM_CLOCK:  prdata = {{(DATA_W-HZ_W){1'b0}}, cfg_q.system_clock_hz};
      REG_MASTER_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.master_mode};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/scds_mul.sv =====
// shared registered multiplier used for every product of the search
module scds_mul
  import scds_pkg::*;
(
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/scds_seq.sv =====
// sequencer: clamp and binary search over prescaler then divisor
module scds_seq
  import scds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  input  logic [HZ_W-1:0]    in_target_hz_i,
  output logic               in_ready_o,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_take_i,
  output logic [MUL_A_W-1:0] mul_a_o,
  output logic [MUL_B_W-1:0] mul_b_o,
  input  logic [MUL_P_W-1:0] mul_p_i
);

  state_e state_q, state_d;

  logic [HZ_W-1:0]  src_q;
  logic [HZ_W-1:0]  target_q;
  logic             master_q;
  logic [LIM_W-1:0] tp1_q;
  logic [PRE_W-1:0] lo_q, hi_q;
  logic [PRE_W-1:0] pre_q;
  logic             phase_q;
  res_t             res_q;

  logic [PRE_W:0]   sum;
  logic [PRE_W-1:0] mid;
  logic [PRE_W-1:0] probe_pre;
  logic [PRE_W-1:0] probe_div;
  logic [HZ_W-1:0]  q12;
  logic [HZ_W-1:0]  lim;
  logic [HZ_W-1:0]  tgt;
  logic             fits;
  logic             accept;
  logic             done_search;

  assign accept      = in_valid_i && in_ready_o;
  assign sum         = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = sum[PRE_W:1];
  assign probe_pre   = phase_q ? pre_q : {mid[RATE_W-1:0] + RATE_W'(1), 1'b0};
  assign probe_div   = phase_q ? mid : DIV_MAX;
  assign q12         = HZ_W'(mul_p_i >> RECIP3_SHIFT);
  assign fits        = {{(RATE_P_W-HZ_W){1'b0}}, src_q} < mul_p_i[RATE_P_W-1:0];
  assign done_search = (lo_q == hi_q);

  always_comb begin
    if (master_q) begin
      lim = (src_q >> 1) > MASTER_CAP_HZ ? MASTER_CAP_HZ : (src_q >> 1);
    end else begin
      lim = q12 > SLAVE_CAP_HZ ? SLAVE_CAP_HZ : q12;
    end
    tgt = target_q > lim ? lim : target_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RECIP;
      ST_RECIP: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_PROD;
      ST_PROD: begin
        if (!done_search) begin
          state_d = ST_SCALE;
        end else if (phase_q || (lo_q == PRE_IDX_NONE)) begin
          state_d = ST_DONE;
        end
      end
      ST_SCALE: state_d = ST_TEST;
      ST_TEST:  state_d = ST_PROD;
      ST_DONE:  if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mul_a_o     = '0;
    mul_b_o     = '0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_RECIP: begin
        mul_a_o = src_q[HZ_W-1:2];
        mul_b_o = RECIP3;
      end
      ST_PROD: begin
        mul_a_o = MUL_A_W'(probe_pre);
        mul_b_o = MUL_B_W'(probe_div);
      end
      ST_SCALE: begin
        mul_a_o = tp1_q;
        mul_b_o = MUL_B_W'(mul_p_i[PROD_W-1:0]);
      end
      ST_DONE:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          src_q    <= cfg_i.source_select ? cfg_i.system_clock_hz : INTERNAL_HZ;
          master_q <= cfg_i.master_mode;
          target_q <= in_target_hz_i;
        end
      end
      ST_CLAMP: begin
        tp1_q   <= tgt[LIM_W-1:0] + LIM_W'(1);
        lo_q    <= '0;
        hi_q    <= PRE_IDX_NONE;
        phase_q <= 1'b0;
      end
      ST_PROD: begin
        if (done_search) begin
          if (phase_q) begin
            res_q.even_prescaler <= pre_q;
            res_q.rate_field     <= RATE_W'(lo_q - PRE_W'(1));
            res_q.no_fit         <= 1'b0;
          end else if (lo_q == PRE_IDX_NONE) begin
            res_q.even_prescaler <= FAIL_PRESCALER;
            res_q.rate_field     <= '0;
            res_q.no_fit         <= 1'b1;
          end else begin
            pre_q   <= {lo_q[RATE_W-1:0] + RATE_W'(1), 1'b0};
            lo_q    <= PRE_W'(1);
            hi_q    <= DIV_MAX;
            phase_q <= 1'b1;
          end
        end
      end
      ST_TEST: begin
        if (fits) begin
          hi_q <= mid;
        end else begin
          lo_q <= mid + PRE_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== tb/serial_clock_divider_search_tb.sv =====
// testbench for serial_clock_divider_search: directed table plus random targets vs a predictor
module serial_clock_divider_search_tb;
  import scds_pkg::*;

  localparam int unsigned SLAVE_RATIO = 12;
  localparam int unsigned PRE_LAST    = 254;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned PHASES      = 3;
  localparam int unsigned BLOCKS      = 4;
  localparam int unsigned BLOCK_WORDS = 10;
  localparam int unsigned DIR_ROWS    = 23;

  typedef struct packed {
    logic              source_select;
    logic [HZ_W-1:0]   system_clock_hz;
    logic              master_mode;
    logic [HZ_W-1:0]   target_hz;
    logic              typed;
    logic [PRE_W-1:0]  even_prescaler;
    logic [RATE_W-1:0] rate_field;
    logic              no_fit;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  scds_in_if  req_if ();
  scds_out_if rsp_if ();

  serial_clock_divider_search u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        cfg_model;
  res_t        div_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned stall_cycles = 0;

  // sel, sysclk, master, target, typed, prescaler, field, no_fit
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 27'd16000000, 1'b1, 27'd0,         1'b1, 9'd256, 8'd0, 1'b1},
    '{1'b0, 27'd16000000, 1'b1, 27'h7FFFFFF,   1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b1, 27'd8000000,   1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b1, 27'd7999999,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b1, 27'd1,         1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b1, 27'h4000000,   1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b0, 27'h7FFFFFF,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b0, 27'd16000000, 1'b0, 27'd0,         1'b1, 9'd256, 8'd0, 1'b1},
    '{1'b1, 27'd0,        1'b1, 27'd0,         1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b1, 27'd0,        1'b1, 27'h7FFFFFF,   1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b1, 27'h7FFFFFF,  1'b1, 27'h7FFFFFF,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b1, 27'h7FFFFFF,  1'b1, 27'd0,         1'b1, 9'd256, 8'd0, 1'b1},
    '{1'b1, 27'h7FFFFFF,  1'b0, 27'd6670000,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b1, 27'd80000000, 1'b0, 27'h7FFFFFF,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b1, 27'd80000000, 1'b0, 27'd0,         1'b1, 9'd256, 8'd0, 1'b1},
    '{1'b1, 27'd80000000, 1'b1, 27'd1300,      1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b1, 27'd80000000, 1'b1, 27'd1,         1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b1, 27'd50000000, 1'b1, 27'd25000000,  1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b1, 27'd1,        1'b1, 27'd0,         1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b1, 27'd1,        1'b0, 27'd5,         1'b1, 9'd2,   8'd0, 1'b0},
    '{1'b1, 27'h5555555,  1'b0, 27'h2AAAAAA,   1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b0, 27'd0,        1'b1, 27'd100,       1'b0, 9'd0,   8'd0, 1'b0},
    '{1'b0, 27'd0,        1'b0, 27'd5555,      1'b0, 9'd0,   8'd0, 1'b0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int unsigned divider_source_hz();
    return cfg_model.source_select ? 32'(cfg_model.system_clock_hz) : 32'(INTERNAL_HZ);
  endfunction

  // first even prescaler, then first divisor, whose truncated rate meets the clamped target
  function automatic res_t predict_divider(input logic [HZ_W-1:0] target);
    int unsigned src;
    int unsigned tgt;
    int unsigned pre;
    int unsigned dv;
    res_t r;
    src = divider_source_hz();
    tgt = 32'(target);
    if (cfg_model.master_mode) begin
      if (tgt > src / 2) tgt = src / 2;
      if (tgt > 32'(MASTER_CAP_HZ)) tgt = 32'(MASTER_CAP_HZ);
    end else begin
      if (tgt > src / SLAVE_RATIO) tgt = src / SLAVE_RATIO;
      if (tgt > 32'(SLAVE_CAP_HZ)) tgt = 32'(SLAVE_CAP_HZ);
    end
    r.even_prescaler = FAIL_PRESCALER;
    r.rate_field = '0;
    r.no_fit = 1'b1;
    for (pre = 2; pre <= PRE_LAST; pre += 2) begin
      if ((src / 32'(DIV_MAX)) / pre > tgt) continue;
      for (dv = 1; dv <= 32'(DIV_MAX); dv++) begin
        if ((src / dv) / pre <= tgt) begin
          r.even_prescaler = PRE_W'(pre);
          r.rate_field = RATE_W'(dv - 1);
          r.no_fit = 1'b0;
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic check_divider_cfg();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, REG_SOURCE_SELECT, '0, rd);
    if (rd !== DATA_W'(cfg_model.source_select))
      report_mismatch($sformatf("source_select read %0h", rd));
    apb_access(1'b0, REG_SYSTEM_CLOCK, '0, rd);
    if (rd !== DATA_W'(cfg_model.system_clock_hz))
      report_mismatch($sformatf("system_clock_hz read %0h", rd));
    apb_access(1'b0, REG_MASTER_MODE, '0, rd);
    if (rd !== DATA_W'(cfg_model.master_mode))
      report_mismatch($sformatf("master_mode read %0h", rd));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_divider_cfg(input cfg_t c);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, REG_SOURCE_SELECT, DATA_W'(c.source_select), rd);
    apb_access(1'b1, REG_SYSTEM_CLOCK, DATA_W'(c.system_clock_hz), rd);
    apb_access(1'b1, REG_MASTER_MODE, DATA_W'(c.master_mode), rd);
    cfg_model = c;
    check_divider_cfg();
  endtask

  task automatic drain_results();
    while (div_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_target(input logic [HZ_W-1:0] t, input res_t want);
    if ($urandom_range(99, 0) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.target_hz <= t;
    do @(posedge clk_i); while (!req_if.ready);
    div_expect_q.push_back(want);
  endtask

  function automatic cfg_t pick_cfg(input int unsigned ph, input int unsigned blk);
    cfg_t c;
    c.source_select = ($urandom_range(3, 0) != 0);
    c.master_mode = 1'($urandom_range(1, 0));
    case ($urandom_range(2, 0))
      0: c.system_clock_hz = HZ_W'($urandom);
      1: c.system_clock_hz = HZ_W'($urandom_range(80000000, 1));
      default: c.system_clock_hz = HZ_W'($urandom_range(20000, 0));
    endcase
    if (blk == 0) begin
      c.source_select = 1'b1;
      case (ph)
        0: c.system_clock_hz = '1;
        1: c.system_clock_hz = HZ_W'(1);
        default: c.system_clock_hz = HZ_W'(80000000);
      endcase
    end
    return c;
  endfunction

  // targets near a rate boundary in two cases of five, else full-range, up to 25 MHz or small ones
  function automatic logic [HZ_W-1:0] pick_target();
    int unsigned src;
    int unsigned t;
    src = divider_source_hz();
    case ($urandom_range(4, 0))
      0: t = 32'(HZ_W'($urandom));
      1: t = $urandom_range(25000000, 0);
      2: t = $urandom_range(3000, 0);
      default: begin
        t = (src / $urandom_range(256, 1)) / (2 * $urandom_range(127, 1));
        t = t + $urandom_range(2, 0);
        if (t != 0) t = t - 1;
      end
    endcase
    return HZ_W'(t);
  endfunction

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (div_expect_q.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = div_expect_q.pop_front();
        if (rsp_if.even_prescaler !== want.even_prescaler)
          report_mismatch($sformatf("even_prescaler got %0d want %0d",
                                    rsp_if.even_prescaler, want.even_prescaler));
        if (rsp_if.rate_field !== want.rate_field)
          report_mismatch($sformatf("rate_field got %0d want %0d",
                                    rsp_if.rate_field, want.rate_field));
        if (rsp_if.no_fit !== want.no_fit)
          report_mismatch($sformatf("no_fit got %0b want %0b", rsp_if.no_fit, want.no_fit));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("serial_clock_divider_search test failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    res_t want;
    req_if.valid <= 1'b0;
    req_if.target_hz <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_model.source_select = 1'b0;
    cfg_model.system_clock_hz = SYSCLK_RESET_HZ;
    cfg_model.master_mode = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_divider_cfg();

    for (int i = 0; i < DIR_ROWS; i++) begin
      c.source_select = dir_rows[i].source_select;
      c.system_clock_hz = dir_rows[i].system_clock_hz;
      c.master_mode = dir_rows[i].master_mode;
      if (c != cfg_model) begin
        req_if.valid <= 1'b0;
        drain_results();
        load_divider_cfg(c);
      end
      if (dir_rows[i].typed) begin
        want.even_prescaler = dir_rows[i].even_prescaler;
        want.rate_field = dir_rows[i].rate_field;
        want.no_fit = dir_rows[i].no_fit;
      end else begin
        want = predict_divider(dir_rows[i].target_hz);
      end
      send_target(dir_rows[i].target_hz, want);
    end
    req_if.valid <= 1'b0;

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin src_idle_pct = 12; snk_idle_pct = 75; end
        1: begin src_idle_pct = 75; snk_idle_pct = 12; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int unsigned blk = 0; blk < BLOCKS; blk++) begin
        drain_results();
        load_divider_cfg(pick_cfg(ph, blk));
        for (int unsigned k = 0; k < BLOCK_WORDS; k++) begin
          logic [HZ_W-1:0] t;
          t = pick_target();
          send_target(t, predict_divider(t));
        end
        req_if.valid <= 1'b0;
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (div_expect_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", div_expect_q.size()));
    if (mismatches == 0) begin
      $display("serial_clock_divider_search test passed");
    end else begin
      $display("serial_clock_divider_search test failed");
    end
    $finish;
  end

endmodule
